FILE: src/bb_pkg.sv
package bb_pkg;

    // Line store depth and the widths that follow from it
    localparam int MAX_LINE = 2048;
    localparam int COL_W    = $clog2(MAX_LINE);
    localparam int WID_W    = COL_W + 1;

    // Register and field widths
    localparam int CFG_W_W    = 12;
    localparam int CFG_H_W    = 16;
    localparam int ROW_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;

    // Neighbourhood sum (at most 9 * 255), count (1 to 9), divider numerator
    localparam int SUM_W  = 12;
    localparam int CNT_W  = 4;
    localparam int NUM_W  = SUM_W + 1;
    localparam int STEP_W = $clog2(CHAN_W);

    localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 16'd480;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Red in the lowest bits
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pix_t;

    // Line store read address selection
    typedef enum logic [1:0] {
        RD_INPUT,
        RD_LEFT,
        RD_MID,
        RD_RIGHT
    } rd_sel_t;

    typedef struct packed {
        logic       take;
        logic       step;
        logic       vec;
        logic       acc;
        logic [1:0] col;
        rd_sel_t    rd_sel;
        logic       div_start;
        logic       emit;
        logic       commit;
    } dp_cmd_t;

    typedef struct packed {
        logic emit_rdy;
        logic div_busy;
        logic out_free;
    } dp_sts_t;

endpackage

FILE: src/bb_div.sv
module bb_div
    import bb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  sum [3],
    input  logic [CNT_W-1:0]  cnt,
    output logic              busy,
    output logic [CHAN_W-1:0] quot [3]
);

    logic [NUM_W-1:0]  rem_reg [3];
    logic [NUM_W-1:0]  dsh_reg;
    logic [CHAN_W-1:0] q_reg [3];
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;

    // Sequence the restoring steps, one quotient bit a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(CHAN_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Round half up: (2*sum + cnt) / (2*cnt), all three channels together
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dsh_reg <= NUM_W'({cnt, 1'b0}) << (CHAN_W - 1);
            for (int ch = 0; ch < 3; ch++)
            begin
                rem_reg[ch] <= NUM_W'({sum[ch], 1'b0}) + NUM_W'(cnt);
                q_reg[ch]   <= '0;
            end
        end
        else if (busy_reg)
        begin
            dsh_reg <= dsh_reg >> 1;
            for (int ch = 0; ch < 3; ch++)
            begin
                if (rem_reg[ch] >= dsh_reg)
                begin
                    rem_reg[ch] <= rem_reg[ch] - dsh_reg;
                    q_reg[ch]   <= {q_reg[ch][CHAN_W-2:0], 1'b1};
                end
                else
                begin
                    q_reg[ch] <= {q_reg[ch][CHAN_W-2:0], 1'b0};
                end
            end
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

FILE: src/bb_ctrl.sv
module bb_ctrl
    import bb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_VEC,
        S_COL0,
        S_COL1,
        S_COL2,
        S_DIVGO,
        S_DIV,
        S_OUT,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through one item
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_LOAD;
            S_LOAD:   state_next = S_VEC;
            S_VEC:    state_next = sts.emit_rdy ? S_COL0 : S_COMMIT;
            S_COL0:   state_next = S_COL1;
            S_COL1:   state_next = S_COL2;
            S_COL2:   state_next = S_DIVGO;
            S_DIVGO:  state_next = S_DIV;
            S_DIV:    if (!sts.div_busy) state_next = S_OUT;
            S_OUT:    if (sts.out_free) state_next = S_COMMIT;
            S_COMMIT: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Decode commands for the datapath
    always_comb
    begin
        cmd = '0;
        cmd.rd_sel = RD_INPUT;
        unique case (state_reg)
            S_IDLE:   cmd.take = in_valid;
            S_LOAD:   cmd.step = 1'b1;
            S_VEC:
            begin
                cmd.vec    = 1'b1;
                cmd.rd_sel = RD_LEFT;
            end
            S_COL0:
            begin
                cmd.acc    = 1'b1;
                cmd.col    = 2'd0;
                cmd.rd_sel = RD_MID;
            end
            S_COL1:
            begin
                cmd.acc    = 1'b1;
                cmd.col    = 2'd1;
                cmd.rd_sel = RD_RIGHT;
            end
            S_COL2:
            begin
                cmd.acc = 1'b1;
                cmd.col = 2'd2;
            end
            S_DIVGO:  cmd.div_start = 1'b1;
            S_DIV:    ;
            S_OUT:    cmd.emit = 1'b1;
            S_COMMIT: cmd.commit = 1'b1;
            default:  ;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

FILE: src/bb_dp.sv
module bb_dp
    import bb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [PIX_W-1:0]      s_tdata,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIX_W-1:0]      m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  dp_cmd_t               cmd,
    output dp_sts_t               sts
);

    logic [CFG_W_W-1:0] frame_width_reg;
    logic [CFG_H_W-1:0] frame_height_reg;
    logic [WID_W-1:0]   w_eff;
    logic [WID_W-1:0]   w_m1;
    logic [ROW_W-1:0]   h_eff;

    logic [COL_W-1:0] in_col_reg;
    logic [ROW_W-1:0] in_row_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [ROW_W-1:0] out_row_reg;

    pix_t             px_reg;
    logic             pixel_mode_reg;
    logic             last_flag_reg;
    logic [COL_W-1:0] st_col_reg;

    // Column vectors: A is the arriving column, B and C the two before it
    pix_t             a_data_reg [3];
    logic [ROW_W-1:0] a_row_reg;
    logic [COL_W-1:0] a_col_reg;
    pix_t             b_data_reg [3];
    logic [ROW_W-1:0] b_row_reg;
    logic [COL_W-1:0] b_col_reg;
    logic             b_vld_reg;
    pix_t             c_data_reg [3];
    logic [ROW_W-1:0] c_row_reg;
    logic [COL_W-1:0] c_col_reg;
    logic             c_vld_reg;

    pix_t             older_mem [MAX_LINE];
    pix_t             newer_mem [MAX_LINE];
    pix_t             rd_old_reg;
    pix_t             rd_new_reg;
    logic [COL_W-1:0] rd_addr;

    logic [SUM_W-1:0] sum_reg [3];
    logic [CNT_W-1:0] cnt_reg;
    logic [CHAN_W-1:0] quot [3];
    logic             div_busy;

    pix_t             m_data_reg;
    logic             m_last_reg;
    logic             m_valid_reg;

    logic             in_last_col;
    logic [ROW_W:0]   or_p1;
    logic [WID_W-1:0] oc_p1;
    logic [ROW_W-1:0] lr;
    logic [COL_W-1:0] lc;
    logic             out_guard;
    logic             next_zero;
    logic             is_last;
    logic             out_free;

    logic [COL_W+1:0] col_u;
    logic             col_in;
    logic [COL_W-1:0] col_idx;
    logic [ROW_W+1:0] row_u;
    logic             row_in;
    logic [ROW_W+1:0] row_dist;
    logic             found;
    pix_t             px_sel;
    pix_t             vec_data [3][3];
    logic [ROW_W-1:0] vec_row [3];
    logic [COL_W-1:0] vec_col [3];
    logic             vec_vld [3];
    logic [SUM_W-1:0] col_sum [3];
    logic [CNT_W-1:0] col_cnt;

    // Clamp the frame size
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = WID_W'(1);
        end
        else if (32'(frame_width_reg) > MAX_LINE)
        begin
            w_eff = WID_W'(MAX_LINE);
        end
        else
        begin
            w_eff = WID_W'(frame_width_reg);
        end
        h_eff = (frame_height_reg == '0) ? ROW_W'(1) : frame_height_reg;
        w_m1  = w_eff - WID_W'(1);
    end

    // Decide whether the next result has all its neighbours
    always_comb
    begin
        in_last_col = ({1'b0, in_col_reg} + WID_W'(1)) >= w_eff;
        or_p1       = {1'b0, out_row_reg} + (ROW_W + 1)'(1);
        oc_p1       = {1'b0, out_col_reg} + WID_W'(1);
        lr          = (or_p1 < {1'b0, h_eff}) ? or_p1[ROW_W-1:0] : h_eff - ROW_W'(1);
        lc          = (oc_p1 < w_eff) ? oc_p1[COL_W-1:0] : w_m1[COL_W-1:0];
        out_guard   = (out_row_reg >= h_eff) || ({1'b0, out_col_reg} >= w_eff);
        next_zero   = (in_row_reg == '0) && (in_col_reg == '0);
        is_last     = (out_row_reg == h_eff - ROW_W'(1)) &&
                      (out_col_reg == w_m1[COL_W-1:0]);
    end

    assign out_free     = !m_valid_reg || m_tready;
    assign sts.emit_rdy = !next_zero && !out_guard &&
                          ((lr < in_row_reg) || ((lr == in_row_reg) && (lc < in_col_reg)));
    assign sts.div_busy = div_busy;
    assign sts.out_free = out_free;

    // Gather one neighbourhood column from the vectors or the line stores
    always_comb
    begin
        vec_data[0] = a_data_reg;
        vec_data[1] = b_data_reg;
        vec_data[2] = c_data_reg;
        vec_row[0]  = a_row_reg;
        vec_row[1]  = b_row_reg;
        vec_row[2]  = c_row_reg;
        vec_col[0]  = a_col_reg;
        vec_col[1]  = b_col_reg;
        vec_col[2]  = c_col_reg;
        vec_vld[0]  = pixel_mode_reg;
        vec_vld[1]  = b_vld_reg;
        vec_vld[2]  = c_vld_reg;

        col_u   = {2'b00, out_col_reg} + {{COL_W{1'b0}}, cmd.col} - (COL_W + 2)'(1);
        col_in  = !col_u[COL_W+1] && (col_u[COL_W:0] < w_eff);
        col_idx = col_u[COL_W-1:0];
        col_sum[0] = '0;
        col_sum[1] = '0;
        col_sum[2] = '0;
        col_cnt    = '0;
        row_u    = '0;
        row_in   = 1'b0;
        row_dist = '0;
        found    = 1'b0;
        px_sel   = '0;

        for (int i = 0; i < 3; i++)
        begin
            row_u  = {2'b00, out_row_reg} + (ROW_W + 2)'(i) - (ROW_W + 2)'(1);
            row_in = !row_u[ROW_W+1] && (row_u[ROW_W:0] < {1'b0, h_eff});
            px_sel = (i == 1) ? rd_new_reg : rd_old_reg;
            found  = 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                row_dist = {2'b00, vec_row[k]} - row_u;
                if (!found && vec_vld[k] && (vec_col[k] == col_idx) && !row_dist[ROW_W+1] &&
                    (row_dist[ROW_W:0] <= (ROW_W + 1)'(2)))
                begin
                    found = 1'b1;
                    if (row_dist[ROW_W:0] == '0)
                    begin
                        px_sel = vec_data[k][2];
                    end
                    else if (row_dist[ROW_W:0] == (ROW_W + 1)'(1))
                    begin
                        px_sel = vec_data[k][1];
                    end
                    else
                    begin
                        px_sel = vec_data[k][0];
                    end
                end
            end
            if (col_in && row_in)
            begin
                col_sum[0] = col_sum[0] + SUM_W'(px_sel.red);
                col_sum[1] = col_sum[1] + SUM_W'(px_sel.green);
                col_sum[2] = col_sum[2] + SUM_W'(px_sel.blue);
                col_cnt    = col_cnt + CNT_W'(1);
            end
        end
    end

    // Select the line store address
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_INPUT: rd_addr = in_col_reg;
            RD_LEFT:  rd_addr = out_col_reg - COL_W'(1);
            RD_MID:   rd_addr = out_col_reg;
            RD_RIGHT: rd_addr = out_col_reg + COL_W'(1);
            default:  rd_addr = in_col_reg;
        endcase
    end

    // Line stores: read every cycle, shift the column down on commit
    always_ff @(posedge clk)
    begin
        rd_old_reg <= older_mem[rd_addr];
        rd_new_reg <= newer_mem[rd_addr];
        if (cmd.commit && pixel_mode_reg)
        begin
            older_mem[st_col_reg] <= a_data_reg[1];
            newer_mem[st_col_reg] <= px_reg;
        end
    end

    // Configuration, positions and vector tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            pixel_mode_reg   <= 1'b0;
            last_flag_reg    <= 1'b0;
            b_vld_reg        <= 1'b0;
            c_vld_reg        <= 1'b0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[CFG_W_W-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[CFG_H_W-1:0];
                endcase
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
                b_vld_reg   <= 1'b0;
                c_vld_reg   <= 1'b0;
            end

            if (cmd.take)
            begin
                pixel_mode_reg <= !s_tuser && (in_row_reg < h_eff);
                last_flag_reg  <= 1'b0;
            end

            // Advance the input position for a pixel
            if (cmd.step && pixel_mode_reg)
            begin
                if (in_last_col)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + ROW_W'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + COL_W'(1);
                end
            end

            // Emit the result and advance the output position
            if (cmd.emit && out_free)
            begin
                if (is_last)
                begin
                    in_col_reg    <= '0;
                    in_row_reg    <= '0;
                    out_col_reg   <= '0;
                    out_row_reg   <= '0;
                    last_flag_reg <= 1'b1;
                end
                else if (oc_p1 >= w_eff)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + ROW_W'(1);
                end
                else
                begin
                    out_col_reg <= out_col_reg + COL_W'(1);
                end
            end

            // Shift the vector tags; a finished frame drops them
            if (cmd.commit)
            begin
                if (last_flag_reg)
                begin
                    b_vld_reg <= 1'b0;
                    c_vld_reg <= 1'b0;
                end
                else if (pixel_mode_reg)
                begin
                    b_vld_reg <= 1'b1;
                    c_vld_reg <= b_vld_reg;
                end
            end

            // Output register
            if (cmd.emit && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            px_reg <= pix_t'(s_tdata);
        end
        if (cmd.step)
        begin
            st_col_reg <= in_col_reg;
            a_row_reg  <= in_row_reg;
            a_col_reg  <= in_col_reg;
        end
        if (cmd.vec)
        begin
            a_data_reg[0] <= rd_old_reg;
            a_data_reg[1] <= rd_new_reg;
            a_data_reg[2] <= px_reg;
            sum_reg[0]    <= '0;
            sum_reg[1]    <= '0;
            sum_reg[2]    <= '0;
            cnt_reg       <= '0;
        end
        if (cmd.acc)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                sum_reg[ch] <= sum_reg[ch] + col_sum[ch];
            end
            cnt_reg <= cnt_reg + col_cnt;
        end
        if (cmd.commit && pixel_mode_reg)
        begin
            b_data_reg <= a_data_reg;
            b_row_reg  <= a_row_reg;
            b_col_reg  <= a_col_reg;
            c_data_reg <= b_data_reg;
            c_row_reg  <= b_row_reg;
            c_col_reg  <= b_col_reg;
        end
        if (cmd.emit && out_free)
        begin
            m_data_reg.red   <= quot[0];
            m_data_reg.green <= quot[1];
            m_data_reg.blue  <= quot[2];
            m_last_reg       <= is_last;
        end
    end

    bb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .sum   (sum_reg),
        .cnt   (cnt_reg),
        .busy  (div_busy),
        .quot  (quot)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

FILE: src/box_blur_3x3.sv
// 3x3 box blur over an RGB frame, divisor normalised to the in-frame neighbours.
// Input stream (s_*): one item per pixel in raster order; s_tuser marks a flush
// item, which carries no pixel and drains one pending result after the frame's
// final pixel. Output stream (m_*): one averaged pixel per item in raster order,
// m_tlast on the frame's final pixel.
// Configuration (cfg_*): index 0 frame width, index 1 frame height; a write
// restarts the frame. Write only while the block holds no unfinished item.
// An item is taken only once the block has finished the previous one. Per
// result the block makes three single-port reads of the two line stores and
// runs the 8-step restoring divider that rounds the three averages.
// A finished result waits in the output register while the next item is
// taken; if the receiver still stalls when the next result is ready, the
// block holds it and stops accepting until m_tready.
// Reset: frame 640 x 480, positions at the frame start, output empty; the
// line stores are not cleared.
module box_blur_3x3
    import bb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // red_in, green_in, blue_in
    input  logic                  s_tuser,   // kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIX_W-1:0]      m_tdata,   // red_out, green_out, blue_out
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    bb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Output register fills only from an emit with room
    a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.emit && sts.out_free))
        else $error("output valid rose without an emit");

    // Divider starts when told
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> sts.div_busy)
        else $error("divider did not start");

    // No item is taken while the divider runs
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !sts.div_busy)
        else $error("ready while divider busy");

endmodule

FILE: tb/box_blur_3x3_tb.sv
module box_blur_3x3_tb;
    import bb_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int IDLE_LIMIT  = 20000;
    localparam int SETTLE      = 40;
    localparam int RAND_ITEMS  = 620;

    typedef struct {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              last;
    } blur_px_t;

    // Edge-normalised box average predictor and store of pending averages
    class blur_scoreboard;
        bit [PIX_W-1:0]    older_row [MAX_LINE];
        bit [PIX_W-1:0]    newer_row [MAX_LINE];
        bit [PIX_W-1:0]    win [2][3];
        bit [PIX_W-1:0]    vec [3][3];
        int unsigned       in_col, in_row, out_col, out_row;
        bit [CFG_W_W-1:0]  width_reg;
        bit [CFG_H_W-1:0]  height_reg;
        blur_px_t          pending_avg [$];
        int                errors;
        int                results_seen;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function int unsigned eff_w();
            int unsigned w;
            w = width_reg;
            if (w == 0) w = 1;
            if (w > MAX_LINE) w = MAX_LINE;
            return w;
        endfunction

        function int unsigned eff_h();
            return height_reg == 0 ? 1 : height_reg;
        endfunction

        function bit frame_busy();
            return (in_col | in_row | out_col | out_row) != 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_FRAME_WIDTH) width_reg = data[CFG_W_W-1:0];
            else height_reg = data;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        endfunction

        // Pixel at (row, col): from the recent columns if still held, else the line stores
        function bit [PIX_W-1:0] pick(int unsigned n, longint unsigned last_idx,
                                      int unsigned w, int unsigned row, int unsigned col);
            longint unsigned idx, pr, pc;
            for (int unsigned k = 0; k < n; k++)
            begin
                if (last_idx < k) break;
                idx = last_idx - k;
                pr  = idx / w;
                pc  = idx % w;
                if (pc == col && row <= pr && row + 2 >= pr)
                    return vec[k][row + 2 - pr];
            end
            if (col >= MAX_LINE) return '0;
            return row == out_row ? newer_row[col] : older_row[col];
        endfunction

        function bit try_emit(int unsigned n, output blur_px_t r);
            int unsigned     w, h, lr, lc, sr, sg, sb, cnt;
            longint unsigned nxt;
            longint          rr, cc;
            bit [PIX_W-1:0]  px;
            w = eff_w();
            h = eff_h();
            nxt = longint'(in_row) * w + in_col;
            sr = 0; sg = 0; sb = 0; cnt = 0;
            if (nxt == 0 || out_row >= h || out_col >= w) return 0;
            lr = out_row + 1 < h ? out_row + 1 : h - 1;
            lc = out_col + 1 < w ? out_col + 1 : w - 1;
            if (longint'(lr) * w + lc >= nxt) return 0;
            for (int dr = -1; dr <= 1; dr++)
            begin
                for (int dc = -1; dc <= 1; dc++)
                begin
                    rr = longint'(out_row) + dr;
                    cc = longint'(out_col) + dc;
                    if (rr < 0 || cc < 0 || rr >= h || cc >= w) continue;
                    px = pick(n, nxt - 1, w, 32'(rr), 32'(cc));
                    sr += px[23:16];
                    sg += px[15:8];
                    sb += px[7:0];
                    cnt++;
                end
            end
            r.red   = CHAN_W'((2 * sr + cnt) / (2 * cnt));
            r.green = CHAN_W'((2 * sg + cnt) / (2 * cnt));
            r.blue  = CHAN_W'((2 * sb + cnt) / (2 * cnt));
            r.last  = (out_row == h - 1 && out_col == w - 1);
            if (r.last)
            begin
                in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            end
            else if (++out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
            return 1;
        endfunction

        // Note one accepted input item; rgb holds red in the top byte
        function void note_input(bit flush, bit [PIX_W-1:0] rgb);
            int unsigned w, h, col;
            blur_px_t    r;
            bit          got;
            w = eff_w();
            h = eff_h();
            if (flush || in_row >= h)
            begin
                vec[0] = win[1];
                vec[1] = win[0];
                vec[2] = '{default: '0};
                if (try_emit(2, r)) pending_avg.push_back(r);
                return;
            end
            col = in_col < MAX_LINE ? in_col : 0;
            vec[0][0] = older_row[col];
            vec[0][1] = newer_row[col];
            vec[0][2] = rgb;
            vec[1] = win[1];
            vec[2] = win[0];
            if (++in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
            got = try_emit(3, r);
            if (got) pending_avg.push_back(r);
            older_row[col] = newer_row[col];
            newer_row[col] = rgb;
            win[0] = win[1];
            win[1] = vec[0];
        endfunction

        task check(logic [PIX_W-1:0] data, logic last);
            blur_px_t e;
            results_seen++;
            if (pending_avg.size() == 0)
            begin
                report($sformatf("unexpected item %h last %b", data, last));
                return;
            end
            e = pending_avg.pop_front();
            if (data[7:0] !== e.red)
                report($sformatf("red %h, want %h", data[7:0], e.red));
            if (data[15:8] !== e.green)
                report($sformatf("green %h, want %h", data[15:8], e.green));
            if (data[23:16] !== e.blue)
                report($sformatf("blue %h, want %h", data[23:16], e.blue));
            if (last !== e.last)
                report($sformatf("last %b, want %b", last, e.last));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [PIX_W-1:0]      m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    blur_scoreboard sb = new();
    int             idle_cycles = 0;
    int             items_sent = 0;
    bit             long_hold_done = 0;

    box_blur_3x3 i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [PIX_W-1:0] rand_pix();
        int p;
        p = $urandom_range(7);
        if (p == 0) return '0;
        if (p == 1) return '1;
        return PIX_W'($urandom());
    endfunction

    // Check every output item as it is taken
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check(m_tdata, m_tlast);
    end

    // Watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: bursts of ready with random stalls, one long hold-off
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk) m_tready <= 1'b1;
            repeat ($urandom_range(0, 15)) @(negedge clk);
            gap = pick_gap();
            if (!long_hold_done && sb.results_seen >= 150)
            begin
                gap = 400;
                long_hold_done = 1;
            end
            if (gap > 0)
            begin
                @(negedge clk) m_tready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    end

    // Offer one item, hold until taken, then idle for a random gap
    task automatic send_item(bit flush, logic [PIX_W-1:0] rgb);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= flush;
        s_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16]};
        do @(posedge clk); while (!s_tready);
        sb.note_input(flush, rgb);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drop valid, wait for every pending average, then let the block settle
    task automatic wait_idle();
        @(negedge clk) s_tvalid <= 1'b0;
        while (sb.pending_avg.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    // Send npix pixels, with stray flush items if asked, then drain unless aborting
    task automatic run_frame(int npix, bit stray, bit drain);
        for (int i = 0; i < npix; i++)
        begin
            if (stray && $urandom_range(19) == 0) send_item(1'b1, rand_pix());
            send_item(1'b0, rand_pix());
        end
        // drain with flushes and some dropped pixels
        while (drain && sb.frame_busy())
            send_item($urandom_range(4) != 0, rand_pix());
    endtask

    initial
    begin
        int w, h;
        repeat (7) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Zero width and flush with nothing ready
        write_reg(REG_FRAME_WIDTH, 16'd0);
        write_reg(REG_FRAME_HEIGHT, 16'd3);
        send_item(1'b1, '0);
        send_item(1'b0, '0);
        send_item(1'b0, '1);
        send_item(1'b1, '1);
        send_item(1'b0, 24'hff00ff);
        send_item(1'b0, 24'h00ff00);
        send_item(1'b1, '0);
        wait_idle();

        // Small frame with extremes, then pixels after the final one
        write_reg(REG_FRAME_WIDTH, 16'd2);
        write_reg(REG_FRAME_HEIGHT, 16'd2);
        send_item(1'b0, '1);
        send_item(1'b0, '0);
        send_item(1'b0, '1);
        send_item(1'b0, 24'h010101);
        send_item(1'b0, 24'h123456);
        send_item(1'b1, '0);
        send_item(1'b0, '1);
        send_item(1'b1, '0);
        wait_idle();

        // Zero height, single pixel frame
        write_reg(REG_FRAME_HEIGHT, 16'd0);
        write_reg(REG_FRAME_WIDTH, 16'd1);
        send_item(1'b0, 24'habcdef);
        send_item(1'b1, '0);
        wait_idle();

        // Random frames, mostly small, some aborted by a register write
        while (items_sent < RAND_ITEMS)
        begin
            w = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
            h = $urandom_range(0, 6);
            if ($urandom_range(1))
            begin
                write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
                write_reg(REG_FRAME_WIDTH, {4'($urandom()), 12'(w)});
            end
            else
            begin
                write_reg(REG_FRAME_WIDTH, {4'($urandom()), 12'(w)});
                write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
            end
            if ($urandom_range(7) == 0)
                run_frame($urandom_range(1, w * (h == 0 ? 1 : h)), 1'b1, 1'b0);
            else
                run_frame(w * (h == 0 ? 1 : h), 1'b1, 1'b1);
            wait_idle();
        end

        // Widest line, clamped from the largest width, single row, aborted
        write_reg(REG_FRAME_WIDTH, 16'h0fff);
        write_reg(REG_FRAME_HEIGHT, 16'd1);
        run_frame(60, 1'b0, 1'b0);
        wait_idle();

        if (sb.pending_avg.size() != 0)
            sb.report($sformatf("%0d averages never arrived", sb.pending_avg.size()));
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
src/bb_pkg.sv
src/bb_div.sv
src/bb_ctrl.sv
src/bb_dp.sv
src/box_blur_3x3.sv
tb/box_blur_3x3_tb.sv
